>>> rtl/core/vsk_pkg.sv
// Shared constants for the four-influence vertex skinning block.
// No dependencies; used by the top level.
package vsk_pkg;

  // store geometry
  localparam int BONE_COUNT       = 64;
  localparam int INFLUENCES       = 4;
  localparam int FIELD_INFLUENCES = 4;
  localparam int NUM_INFL         = (INFLUENCES < FIELD_INFLUENCES) ? INFLUENCES
                                                                    : FIELD_INFLUENCES;
  localparam int ROWS             = 3;
  localparam int COLS             = 4;
  localparam int WORDS_PER_BONE   = ROWS * COLS;
  localparam int BONE_AW          = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

  // field widths
  localparam int BONE_W   = 6;
  localparam int WEIGHT_W = 16;

  // Q1.15 one, used to clamp weights
  localparam logic [WEIGHT_W:0] WEIGHT_ONE = 17'd32768;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SKIN = 1'b1;

endpackage

>>> rtl/core/vsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/vertex_skinning_four_bones_top.sv
// Vertex path registers: RAM read, products, row sums, weighted terms, blend.
// Throughput: one transaction (load or vertex) per cycle while not stalled;
//   48 bone-store RAM copies (one per influence and matrix word) read together.
// Back pressure freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n, synchronous) clears valid bits only; the matrix store
//   holds garbage until written.
// Depends on vsk_pkg and vsk_ram.
module vertex_skinning_four_bones_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [5:0]         in_load_bone,
  input  logic [3:0]         in_load_element,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [23:0]        in_bone_set,
  input  logic [63:0]        in_weight_set,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_skinned_x,
  output logic signed [31:0] out_skinned_y,
  output logic signed [31:0] out_skinned_z
);

  localparam int NI = vsk_pkg::NUM_INFL;
  localparam int NW = vsk_pkg::WORDS_PER_BONE;
  localparam int NR = vsk_pkg::ROWS;
  localparam int WW = vsk_pkg::WEIGHT_W;

  // pipeline advance: move whenever the output register is empty or its result is taken
  logic adv, accept, wr_ok;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign wr_ok    = accept && (in_cmd == vsk_pkg::CMD_LOAD) &&
                    (32'(in_load_element) < NW) &&
                    (32'(in_load_bone) < vsk_pkg::BONE_COUNT);

  // matrix store: one RAM per influence and word
  logic signed [31:0] rd [NI][NW];

  for (genvar i = 0; i < NI; i++) begin : g_infl
    for (genvar e = 0; e < NW; e++) begin : g_word
      vsk_ram #(.WIDTH(32), .DEPTH(vsk_pkg::BONE_COUNT)) u_ram (
        .clk     (clk),
        .wr_en   (wr_ok && (32'(in_load_element) == e)),
        .wr_addr (vsk_pkg::BONE_AW'(in_load_bone)),
        .wr_data (in_load_value),
        .rd_en   (adv),
        .rd_addr (vsk_pkg::BONE_AW'(in_bone_set[i*vsk_pkg::BONE_W +: vsk_pkg::BONE_W])),
        .rd_data (rd[i][e])
      );
    end
  end

  // pipeline registers
  logic               s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic signed [31:0] pos1_r [3];
  logic [WW:0]        w1_r [NI];
  logic [WW:0]        w2_r [NI];
  logic [WW:0]        w3_r [NI];
  logic signed [63:0] p_r  [NI][NR][3];
  logic signed [31:0] m3_r [NI][NR];
  logic signed [50:0] t_r  [NI][NR];
  logic signed [67:0] c_r  [NI][NR];
  logic signed [31:0] sk_r [NR];

  // clamped, masked weights for the incoming transaction
  logic [WW:0] w_in [NI];
  always_comb begin
    logic [WW-1:0] wf;
    logic [5:0]    bn;
    for (int i = 0; i < NI; i++) begin
      wf = in_weight_set[i*WW +: WW];
      bn = in_bone_set[i*vsk_pkg::BONE_W +: vsk_pkg::BONE_W];
      if (32'(bn) >= vsk_pkg::BONE_COUNT) begin
        w_in[i] = '0;
      end else if ({1'b0, wf} > vsk_pkg::WEIGHT_ONE) begin
        w_in[i] = vsk_pkg::WEIGHT_ONE;
      end else begin
        w_in[i] = {1'b0, wf};
      end
    end
  end

  // row transforms: floor(sum/2^16) + translation
  logic signed [50:0] t_nxt [NI][NR];
  always_comb begin
    logic signed [65:0] s;
    for (int i = 0; i < NI; i++) begin
      for (int r = 0; r < NR; r++) begin
        s = 66'(p_r[i][r][0]) + 66'(p_r[i][r][1]) + 66'(p_r[i][r][2]);
        t_nxt[i][r] = 51'(s >>> 16) + 51'(m3_r[i][r]);
      end
    end
  end

  // blend over influences, floor by 2^15, saturate
  logic signed [31:0] sk_nxt [NR];
  always_comb begin
    logic signed [69:0] acc;
    logic signed [54:0] sh;
    for (int r = 0; r < NR; r++) begin
      acc = '0;
      for (int i = 0; i < NI; i++) begin
        acc = acc + 70'(c_r[i][r]);
      end
      sh = 55'(acc >>> 15);
      if (sh > 55'sh7FFFFFFF) begin
        sk_nxt[r] = 32'sh7FFFFFFF;
      end else if (sh < -55'sh80000000) begin
        sk_nxt[r] = 32'sh80000000;
      end else begin
        sk_nxt[r] = 32'(sh);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= accept && (in_cmd == vsk_pkg::CMD_SKIN);
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      pos1_r[0] <= in_pos_x;
      pos1_r[1] <= in_pos_y;
      pos1_r[2] <= in_pos_z;
      for (int i = 0; i < NI; i++) begin
        w1_r[i] <= w_in[i];
        w2_r[i] <= w1_r[i];
        w3_r[i] <= w2_r[i];
        for (int r = 0; r < NR; r++) begin
          for (int c = 0; c < 3; c++) begin
            p_r[i][r][c] <= rd[i][r*vsk_pkg::COLS+c] * pos1_r[c];
          end
          m3_r[i][r] <= rd[i][r*vsk_pkg::COLS+3];
          t_r[i][r]  <= t_nxt[i][r];
          c_r[i][r]  <= t_r[i][r] * $signed({1'b0, w3_r[i]});
        end
      end
      for (int r = 0; r < NR; r++) begin
        sk_r[r] <= sk_nxt[r];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_skinned_x = sk_r[0];
  assign out_skinned_y = sk_r[1];
  assign out_skinned_z = sk_r[2];

  // checks
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd == vsk_pkg::CMD_LOAD) |=> !s1_valid_r)
    else $error("load transaction entered the skin pipeline");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && adv) |=> out_valid_r)
    else $error("last stage lost a transaction");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(s2_valid_r) && $stable(s3_valid_r) && $stable(s4_valid_r)))
    else $error("pipeline moved while stalled");

endmodule
